@@ src/gng_pkg.sv @@
package gng_pkg;

    // Default sizes handed to the top level.
    localparam int TABLE_SIZE_DEF    = 256;
    localparam int FRACTION_BITS_DEF = 16;

    // Datapath widths.
    localparam int W_OP     = 33;
    localparam int W_PROD   = 2 * W_OP;
    localparam int W_OUT    = 19;
    localparam int W_PERIOD = 16;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_NOISE_1D = 2'd0;
    localparam logic [1:0] CMD_NOISE_2D = 2'd1;
    localparam logic [1:0] CMD_RESEED   = 2'd2;

    // Result kinds carried in the output tuser.
    localparam logic KIND_NOISE = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    // Register indexes.
    localparam logic REG_PERIOD_X = 1'b0;
    localparam logic REG_PERIOD_Y = 1'b1;

    localparam logic [W_PERIOD-1:0] PERIOD_RESET = 16'd256;

    // Generator constants.
    localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC = 64'd105;

    // Output scale factors, Q0.24.
    localparam logic signed [W_OP-1:0] SCALE_1D = 33'sd3154117;
    localparam logic signed [W_OP-1:0] SCALE_2D = 33'sd8506049;
    localparam int SCALE_BITS = 24;

    localparam logic signed [W_PROD-1:0] OUT_MAX = 66'sd262143;
    localparam logic signed [W_PROD-1:0] OUT_MIN = -66'sd262144;

    // Round to nearest, ties away from zero, then drop sh fraction bits.
    function automatic logic signed [W_PROD-1:0] round_shift(
        input logic signed [W_PROD-1:0] v, input int sh);
        logic [W_PROD-1:0] mag;
        logic [W_PROD-1:0] half;
        logic [W_PROD-1:0] r;
        mag  = v[W_PROD-1] ? W_PROD'(-v) : W_PROD'(v);
        half = W_PROD'(1) << (sh - 1);
        r    = (mag + half) >> sh;
        return v[W_PROD-1] ? -$signed(r) : $signed(r);
    endfunction

    // Output permutation of the generator: xorshift, then data-driven rotate.
    function automatic logic [31:0] gen_out(input logic [63:0] s);
        logic [31:0] sft;
        logic [4:0]  rot;
        sft = 32'(((s >> 18) ^ s) >> 27);
        rot = s[63:59];
        return (sft >> rot) | (sft << 5'(-rot));
    endfunction

    // One-dimensional gradient: slope 1..8 with sign.
    function automatic logic signed [W_OP-1:0] slope1(
        input logic [3:0] h, input logic signed [W_OP-1:0] x);
        logic signed [4:0]      g;
        logic signed [W_OP+4:0] p;
        g = $signed({1'b0, 4'({1'b0, h[2:0]} + 4'd1)});
        p = x * g;
        return h[3] ? W_OP'(-p) : W_OP'(p);
    endfunction

    // Two-dimensional gradient from eight directions.
    function automatic logic signed [W_OP-1:0] slope2(
        input logic [3:0] h, input logic signed [W_OP-1:0] x,
        input logic signed [W_OP-1:0] y);
        logic signed [W_OP-1:0] u;
        logic signed [W_OP-1:0] v;
        logic signed [W_OP-1:0] v2;
        u  = h[2] ? y : x;
        v  = h[2] ? x : y;
        v2 = v <<< 1;
        return (h[0] ? -u : u) + (h[1] ? -v2 : v2);
    endfunction

endpackage

@@ src/gradient_noise_generator.sv @@
// Channel    | Direction | Carries
// s_axis     | in        | command: tuser = cmd, tdata = coord_x, coord_y, seed_value
// m_axis     | out       | result:  tuser = result_kind, tdata = noise_value
// APB        | in/out    | period_x at 0x0, period_y at 0x4
//
// One command is worked at a time. A noise command takes four serial remainders,
// two or six table reads, and six (1D) or twelve (2D) passes through the shared
// multiplier. A reseed first clears the used-value map, then advances the generator
// in the shared multiplier for each draw.
// Reset is synchronous and active low. The next command is taken while a result
// still waits for the output side; the result register holds until it is taken.
module gradient_noise_generator
    import gng_pkg::*;
#(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] coord_x, [63:32] coord_y, [127:64] seed_value
    input  logic [127:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [18:0] noise_value, [23:19] zero
    output logic [23:0]  m_axis_tdata,
    // [0] result_kind
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW   = $clog2(TABLE_SIZE);
    localparam int W_I  = 34 - FRACTION_BITS;
    localparam int BW   = $clog2(W_I + 1);
    localparam logic signed [W_OP-1:0] ONE_FX = W_OP'(1) << FRACTION_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MODL  = 4'd1;
    localparam logic [3:0] S_MODI  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_SLOPE = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CLR   = 4'd6;
    localparam logic [3:0] S_GEN   = 4'd7;
    localparam logic [3:0] S_GCHK  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Multiplier program steps.
    localparam logic [3:0] OP_FADE_X  = 4'd0;
    localparam logic [3:0] OP_FADE_XE = 4'd3;
    localparam logic [3:0] OP_FADE_Y  = 4'd4;
    localparam logic [3:0] OP_FADE_YE = 4'd7;
    localparam logic [3:0] OP_LERP_Y0 = 4'd8;
    localparam logic [3:0] OP_LERP_Y1 = 4'd9;
    localparam logic [3:0] OP_LERP_X  = 4'd10;
    localparam logic [3:0] OP_SCALE   = 4'd11;
    localparam logic [3:0] OP_GEN_LL  = 4'd12;
    localparam logic [3:0] OP_GEN_LH  = 4'd13;
    localparam logic [3:0] OP_GEN_HL  = 4'd14;

    // Memories and their read registers.
    logic [AW-1:0] perm_mem [TABLE_SIZE];
    logic          used_mem [TABLE_SIZE];
    logic [AW-1:0] r_perm_q;
    logic          r_used_q;

    // Control state.
    logic [3:0]    r_state;
    logic [1:0]    r_cmd;
    logic [3:0]    r_op;
    logic [1:0]    r_ph;
    logic [1:0]    r_mi;
    logic [BW-1:0] r_bit;
    logic [2:0]    r_rk;
    logic          r_rph;
    logic [AW-1:0] r_i;
    logic          r_init;
    logic          r_ovalid;

    // Configuration.
    logic [W_PERIOD-1:0] r_px;
    logic [W_PERIOD-1:0] r_py;

    // Payload registers.
    logic [63:0]            r_gen;
    logic [63:0]            r_acc;
    logic [AW-1:0]          r_v;
    logic signed [W_I-1:0]  r_ix;
    logic signed [W_I-1:0]  r_iy;
    logic signed [W_OP-1:0] r_fx0;
    logic signed [W_OP-1:0] r_fy0;
    logic                   r_neg;
    logic [W_I-1:0]         r_dvd;
    logic [W_I-1:0]         r_mag;
    logic [W_PERIOD-1:0]    r_rem;
    logic [AW-1:0]          r_w [4];
    logic [AW-1:0]          r_h [6];
    logic signed [W_OP-1:0] r_a00, r_a01, r_a10, r_a11;
    logic signed [W_OP-1:0] r_n0, r_n1, r_n;
    logic signed [W_OP-1:0] r_s, r_t, r_tmp;
    logic signed [W_OP-1:0] r_ma, r_mb;
    logic signed [W_PROD-1:0] r_prod;
    logic [W_OUT-1:0]       r_res;
    logic [W_OUT-1:0]       r_onoise;
    logic                   r_okind;

    logic s_acc, m_acc, cfg_wr;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_acc  = m_axis_tvalid && m_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_onoise};
    assign m_axis_tuser  = r_okind;
    assign pready        = 1'b1;
    assign prdata = (paddr[2] == REG_PERIOD_Y) ? {16'b0, r_py} : {16'b0, r_px};

    // Split the incoming coordinates into lattice cell and fraction.
    logic signed [31:0]     in_x, in_y;
    logic signed [W_I-1:0]  sp_ix, sp_iy;
    logic signed [W_OP-1:0] sp_fx, sp_fy;
    always_comb begin
        in_x  = $signed(s_axis_tdata[31:0]);
        in_y  = $signed(s_axis_tdata[63:32]);
        sp_ix = W_I'(in_x >>> FRACTION_BITS);
        sp_iy = W_I'(in_y >>> FRACTION_BITS);
        sp_fx = $signed(W_OP'(in_x[FRACTION_BITS-1:0]));
        sp_fy = $signed(W_OP'(in_y[FRACTION_BITS-1:0]));
        // An exact integer lands at the top of the cell below.
        if (in_x[FRACTION_BITS-1:0] == '0) begin
            sp_ix = sp_ix - W_I'(1);
            sp_fx = ONE_FX;
        end
        if (in_y[FRACTION_BITS-1:0] == '0) begin
            sp_iy = sp_iy - W_I'(1);
            sp_fy = ONE_FX;
        end
    end

    // Serial remainder unit operands.
    logic signed [W_I-1:0] md_a;
    logic [W_PERIOD-1:0]   md_p;
    logic [W_PERIOD:0]     md_sh;
    logic [W_PERIOD-1:0]   md_nx;
    logic [AW-1:0]         md_low;
    logic [AW-1:0]         md_idx;
    always_comb begin
        case (r_mi)
            2'd0:    md_a = r_ix;
            2'd1:    md_a = r_ix + W_I'(1);
            2'd2:    md_a = r_iy;
            default: md_a = r_iy + W_I'(1);
        endcase
        md_p   = r_mi[1] ? r_py : r_px;
        md_sh  = {r_rem, r_dvd[W_I-1]};
        md_nx  = (md_sh >= {1'b0, md_p}) ? W_PERIOD'(md_sh - {1'b0, md_p})
                                         : W_PERIOD'(md_sh);
        md_low = (md_p == '0) ? r_mag[AW-1:0] : md_nx[AW-1:0];
        md_idx = r_neg ? AW'(-md_low) : md_low;
    end

    // Table read address for each read step.
    logic          is_2d;
    logic [AW-1:0] rd_addr;
    logic [2:0]    rd_last;
    assign is_2d   = (r_cmd == CMD_NOISE_2D);
    assign rd_last = is_2d ? 3'd5 : 3'd1;
    always_comb begin
        case (r_rk)
            3'd0:    rd_addr = is_2d ? r_w[2] : r_w[0];
            3'd1:    rd_addr = is_2d ? r_w[3] : r_w[1];
            3'd2:    rd_addr = r_w[0] + r_h[0];
            3'd3:    rd_addr = r_w[0] + r_h[1];
            3'd4:    rd_addr = r_w[1] + r_h[0];
            default: rd_addr = r_w[1] + r_h[1];
        endcase
    end

    // Multiplier operand selection for the current program step.
    logic signed [W_OP-1:0] fx1, fy1, fsel, mul_a, mul_b;
    assign fx1  = r_fx0 - ONE_FX;
    assign fy1  = r_fy0 - ONE_FX;
    assign fsel = (r_op < OP_FADE_Y) ? r_fx0 : r_fy0;
    always_comb begin
        case (r_op)
            OP_FADE_X, OP_FADE_Y: begin
                mul_a = fsel;
                mul_b = (fsel <<< 2) + (fsel <<< 1) - (ONE_FX <<< 4) + ONE_FX;
            end
            OP_LERP_Y0: begin
                mul_a = r_t;
                mul_b = r_a01 - r_a00;
            end
            OP_LERP_Y1: begin
                mul_a = r_t;
                mul_b = r_a11 - r_a10;
            end
            OP_LERP_X: begin
                mul_a = r_s;
                mul_b = r_n1 - r_n0;
            end
            OP_SCALE: begin
                mul_a = r_n;
                mul_b = is_2d ? SCALE_2D : SCALE_1D;
            end
            OP_GEN_LL: begin
                mul_a = $signed({1'b0, r_gen[31:0]});
                mul_b = $signed({1'b0, PCG_MUL[31:0]});
            end
            OP_GEN_LH: begin
                mul_a = $signed({1'b0, r_gen[31:0]});
                mul_b = $signed({1'b0, PCG_MUL[63:32]});
            end
            OP_GEN_HL: begin
                mul_a = $signed({1'b0, r_gen[63:32]});
                mul_b = $signed({1'b0, PCG_MUL[31:0]});
            end
            default: begin
                mul_a = fsel;
                mul_b = r_tmp;
            end
        endcase
    end

    // Rounded products and the saturated output.
    logic signed [W_PROD-1:0] rs_fb, rs_sc;
    logic signed [W_OP-1:0]   res_fb;
    logic [W_OUT-1:0]         res_sat;
    always_comb begin
        rs_fb  = round_shift(r_prod, FRACTION_BITS);
        rs_sc  = round_shift(r_prod, SCALE_BITS);
        res_fb = W_OP'(rs_fb);
        if (rs_sc > OUT_MAX) begin
            res_sat = W_OUT'(OUT_MAX);
        end else if (rs_sc < OUT_MIN) begin
            res_sat = W_OUT'(OUT_MIN);
        end else begin
            res_sat = W_OUT'(rs_sc);
        end
    end

    // Generator draw for the current state.
    logic [AW-1:0] gen_v;
    assign gen_v = AW'(gen_out(r_gen));

    // Memory access control.
    logic          perm_we, used_we, used_wd, perm_re, used_re;
    logic [AW-1:0] used_wa;
    always_comb begin
        perm_we = (r_state == S_GCHK) && !r_used_q;
        used_we = (r_state == S_CLR) || ((r_state == S_GCHK) && !r_used_q);
        used_wd = (r_state == S_GCHK);
        used_wa = (r_state == S_CLR) ? r_i : r_v;
        perm_re = (r_state == S_RD) && !r_rph;
        used_re = (r_state == S_GEN);
    end

    // Permutation table memory.
    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            perm_mem[r_i] <= r_v;
        end
        if (perm_re) begin
            r_perm_q <= perm_mem[rd_addr];
        end
    end

    // Used-value map memory.
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            used_mem[used_wa] <= used_wd;
        end
        if (used_re) begin
            r_used_q <= used_mem[gen_v];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= PERIOD_RESET;
            r_py <= PERIOD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PERIOD_X) begin
                r_px <= pwdata[W_PERIOD-1:0];
            end else begin
                r_py <= pwdata[W_PERIOD-1:0];
            end
        end
    end

    // Output register: holds a result until the output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ovalid || m_acc)) begin
            r_ovalid <= 1'b1;
            r_onoise <= (r_cmd == CMD_RESEED) ? '0 : r_res;
            r_okind  <= (r_cmd == CMD_RESEED) ? KIND_ACK : KIND_NOISE;
        end else if (m_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= '0;
            r_op    <= '0;
            r_ph    <= '0;
            r_mi    <= '0;
            r_bit   <= '0;
            r_rk    <= '0;
            r_rph   <= 1'b0;
            r_i     <= '0;
            r_init  <= 1'b0;
            r_cmd   <= CMD_NOISE_1D;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_cmd <= s_axis_tuser;
                        r_ix  <= sp_ix;
                        r_iy  <= sp_iy;
                        r_fx0 <= sp_fx;
                        r_fy0 <= sp_fy;
                        r_mi  <= '0;
                        r_i   <= '0;
                        if (s_axis_tuser == CMD_RESEED) begin
                            // Seeding: state 0 advanced once is the increment.
                            r_gen   <= PCG_INC ^ s_axis_tdata[127:64];
                            r_init  <= 1'b1;
                            r_state <= S_CLR;
                        end else if (s_axis_tuser == CMD_NOISE_1D ||
                                     s_axis_tuser == CMD_NOISE_2D) begin
                            r_state <= S_MODL;
                        end
                    end
                end

                // Load one lattice index into the remainder unit.
                S_MODL: begin
                    r_neg   <= md_a[W_I-1];
                    r_dvd   <= md_a[W_I-1] ? W_I'(-md_a) : W_I'(md_a);
                    r_mag   <= md_a[W_I-1] ? W_I'(-md_a) : W_I'(md_a);
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= S_MODI;
                end

                // One quotient bit per cycle.
                S_MODI: begin
                    r_rem <= md_nx;
                    r_dvd <= r_dvd << 1;
                    r_bit <= r_bit + BW'(1);
                    if (r_bit == BW'(W_I - 1)) begin
                        r_w[r_mi] <= md_idx;
                        r_mi      <= r_mi + 2'd1;
                        if (r_mi == 2'd3) begin
                            r_rk    <= '0;
                            r_rph   <= 1'b0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_MODL;
                        end
                    end
                end

                // Table reads: issue, then capture.
                S_RD: begin
                    r_rph <= !r_rph;
                    if (r_rph) begin
                        r_h[r_rk] <= r_perm_q;
                        r_rk      <= r_rk + 3'd1;
                        if (r_rk == rd_last) begin
                            r_state <= S_SLOPE;
                        end
                    end
                end

                // Gradients at the cell corners.
                S_SLOPE: begin
                    r_n0    <= slope1(r_h[0][3:0], r_fx0);
                    r_n1    <= slope1(r_h[1][3:0], fx1);
                    r_a00   <= slope2(r_h[2][3:0], r_fx0, r_fy0);
                    r_a01   <= slope2(r_h[3][3:0], r_fx0, fy1);
                    r_a10   <= slope2(r_h[4][3:0], fx1, r_fy0);
                    r_a11   <= slope2(r_h[5][3:0], fx1, fy1);
                    r_op    <= OP_FADE_X;
                    r_ph    <= '0;
                    r_state <= S_MUL;
                end

                // Shared multiplier: operands, product, rounding and write back.
                S_MUL: begin
                    case (r_ph)
                        2'd0: begin
                            r_ma <= mul_a;
                            r_mb <= mul_b;
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_prod <= r_ma * r_mb;
                            r_ph   <= 2'd2;
                        end
                        default: begin
                            r_ph <= 2'd0;
                            // A 1D command skips the y fade and the y blends.
                            if ((r_op == OP_FADE_XE) && !is_2d) begin
                                r_op <= OP_LERP_X;
                            end else begin
                                r_op <= r_op + 4'd1;
                            end
                            case (r_op)
                                OP_FADE_X, OP_FADE_Y: begin
                                    r_tmp <= res_fb + (ONE_FX <<< 3) + (ONE_FX <<< 1);
                                end
                                OP_FADE_XE: begin
                                    r_s <= res_fb;
                                end
                                OP_FADE_YE: begin
                                    r_t <= res_fb;
                                end
                                OP_LERP_Y0: begin
                                    r_n0 <= r_a00 + res_fb;
                                end
                                OP_LERP_Y1: begin
                                    r_n1 <= r_a10 + res_fb;
                                end
                                OP_LERP_X: begin
                                    r_n <= r_n0 + res_fb;
                                end
                                OP_SCALE: begin
                                    r_res   <= res_sat;
                                    r_state <= S_OUT;
                                end
                                OP_GEN_LL: begin
                                    r_acc <= r_prod[63:0];
                                end
                                OP_GEN_LH: begin
                                    r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                                end
                                OP_GEN_HL: begin
                                    r_gen <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]}
                                             + PCG_INC;
                                    r_state <= r_init ? S_GEN : S_GCHK;
                                    r_init  <= 1'b0;
                                end
                                default: begin
                                    r_tmp <= res_fb;
                                end
                            endcase
                        end
                    endcase
                end

                // Clear the used-value map, one entry per cycle.
                S_CLR: begin
                    r_i <= r_i + AW'(1);
                    if (r_i == LAST_IDX) begin
                        r_op    <= OP_GEN_LL;
                        r_ph    <= '0;
                        r_state <= S_MUL;
                    end
                end

                // Draw a candidate, look it up and advance the generator.
                S_GEN: begin
                    r_v     <= gen_v;
                    r_op    <= OP_GEN_LL;
                    r_ph    <= '0;
                    r_state <= S_MUL;
                end

                // Place the candidate unless it is already taken.
                S_GCHK: begin
                    if (r_used_q) begin
                        r_state <= S_GEN;
                    end else if (r_i == LAST_IDX) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_GEN;
                    end
                end

                S_OUT: begin
                    if (!r_ovalid || m_acc) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/gradient_noise_generator_test.sv @@
`timescale 1ns / 1ps

module gradient_noise_generator_test;
    import gng_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int IDLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic signed [18:0] noise;
        logic               kind;
    } noise_result_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    gradient_noise_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: its own copy of the table, the generator and the periods.
    logic [7:0]  perm_tab [256];
    bit          used_map [256];
    logic [63:0] gen_st;
    logic [15:0] per_x;
    logic [15:0] per_y;

    noise_result_t pending_results[$];
    int  error_count;
    int  sent_count;
    int  result_count;
    int  reseed_count;
    int  idle_cycles;
    bit  stall_free;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Generator advance: returns the state before the step.
    function automatic logic [63:0] gen_advance();
        logic [63:0] old;
        old = gen_st;
        gen_st = old * PCG_MUL + PCG_INC;
        return old;
    endfunction

    function automatic logic [31:0] gen_draw();
        logic [63:0] old;
        logic [31:0] sft;
        logic [4:0]  rot;
        old = gen_advance();
        sft = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (sft >> rot) | (sft << ((32 - int'(rot)) & 31));
    endfunction

    function automatic void refill_table(input logic [63:0] seed);
        logic [7:0] v;
        for (int i = 0; i < 256; i++) used_map[i] = 1'b0;
        gen_st = '0;
        void'(gen_advance());
        gen_st ^= seed;
        void'(gen_advance());
        for (int i = 0; i < 256; i++) begin
            v = gen_draw()[7:0];
            while (used_map[v]) v = gen_draw()[7:0];
            perm_tab[i] = v;
            used_map[v] = 1'b1;
        end
    endfunction

    // Round half away from zero, then drop sh fraction bits.
    function automatic longint rshift_round(input longint v, input int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v >= 0) return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return rshift_round(a * b, 16);
    endfunction

    // Floor that treats an exact integer as the cell below with fraction 1.0.
    function automatic void split_fixed(input logic signed [31:0] raw,
                                        output longint ipart, output longint frac);
        longint x;
        x = longint'(raw);
        ipart = x >>> 16;
        frac = x - ipart * 65536;
        if (frac == 0) begin
            ipart -= 1;
            frac = 65536;
        end
    endfunction

    // Truncating modulo keeps the sign; the bits are then masked to the table.
    function automatic logic [7:0] lattice_index(input longint a, input logic [15:0] p);
        longint r;
        r = a;
        if (p != 0) r = (a >= 0) ? (a % longint'(p)) : -((-a) % longint'(p));
        return r[7:0];
    endfunction

    function automatic longint smooth_fade(input longint t);
        longint b;
        b = fx_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
        return fx_mul(t, fx_mul(t, fx_mul(t, b)));
    endfunction

    function automatic longint blend(input longint t, input longint a, input longint b);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic longint grad_1d(input logic [7:0] h, input longint x);
        longint g;
        g = 1 + longint'(h[2:0]);
        if (h[3]) g = -g;
        return g * x;
    endfunction

    function automatic longint grad_2d(input logic [7:0] h, input longint x, input longint y);
        longint u;
        longint v;
        u = h[2] ? y : x;
        v = h[2] ? x : y;
        return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
    endfunction

    function automatic logic [18:0] scale_clamp(input longint n, input longint k);
        longint r;
        r = rshift_round(n * k, 24);
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r[18:0];
    endfunction

    // Expected result of one command; returns 0 when the command yields none.
    function automatic bit compute_noise(input logic [1:0] cmd, input logic [31:0] cx,
                                         input logic [31:0] cy, input logic [63:0] seed,
                                         output noise_result_t res);
        longint ix, fx0, fx1, iy, fy0, fy1, s, t, a0, a1, n0, n1;
        logic [7:0] x0, x1, y0, y1, p0, p1;
        res = '0;
        if (cmd == CMD_RESERVED) return 1'b0;
        if (cmd == CMD_RESEED) begin
            refill_table(seed);
            res.kind = KIND_ACK;
            return 1'b1;
        end
        res.kind = KIND_NOISE;
        split_fixed(cx, ix, fx0);
        fx1 = fx0 - 65536;
        x0 = lattice_index(ix, per_x);
        x1 = lattice_index(ix + 1, per_x);
        s = smooth_fade(fx0);
        if (cmd == CMD_NOISE_1D) begin
            n0 = grad_1d(perm_tab[x0], fx0);
            n1 = grad_1d(perm_tab[x1], fx1);
            res.noise = scale_clamp(blend(s, n0, n1), 3154117);
        end else begin
            split_fixed(cy, iy, fy0);
            fy1 = fy0 - 65536;
            y0 = lattice_index(iy, per_y);
            y1 = lattice_index(iy + 1, per_y);
            t = smooth_fade(fy0);
            p0 = perm_tab[y0];
            p1 = perm_tab[y1];
            a0 = grad_2d(perm_tab[8'(x0 + p0)], fx0, fy0);
            a1 = grad_2d(perm_tab[8'(x0 + p1)], fx0, fy1);
            n0 = blend(t, a0, a1);
            a0 = grad_2d(perm_tab[8'(x1 + p0)], fx1, fy0);
            a1 = grad_2d(perm_tab[8'(x1 + p1)], fx1, fy1);
            n1 = blend(t, a0, a1);
            res.noise = scale_clamp(blend(s, n0, n1), 8506049);
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none during stall-free stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (stall_free || r < 55) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Drive one command and wait for the transaction; record its expectation.
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] cx,
                                input logic [31:0] cy, input logic [63:0] seed);
        noise_result_t res;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {seed, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (compute_noise(cmd, cx, cy, seed, res)) pending_results.push_back(res);
        if (cmd == CMD_RESEED) reseed_count++;
        sent_count++;
        @(negedge i_clk);
    endtask

    // Let all expected results arrive, plus time for an ignored command to finish.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(65535)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PERIOD_X) per_x = value;
        else per_y = value;
    endtask

    function automatic logic [31:0] random_coord();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 32'($signed($urandom_range(2000000)) - 1000000);
        if (r < 60) return {16'($signed($urandom_range(1200)) - 600), 16'h0000};
        if (r < 65) return {16'($urandom), 16'($urandom_range(2)) - 16'd1};
        return $urandom();
    endfunction

    task automatic test_reseed();
        send_command(CMD_RESEED, '0, '0, 64'd0);
        send_command(CMD_NOISE_1D, 32'h0001_8000, '0, '0);
        send_command(CMD_RESEED, $urandom(), $urandom(), '1);
        send_command(CMD_NOISE_2D, 32'h0000_4000, 32'h0003_C000, '0);
        send_command(CMD_RESEED, '0, '0, {$urandom(), $urandom()});
    endtask

    // Field extremes, exact integers, negative lattice cells and the reserved code.
    task automatic test_coordinate_extremes();
        logic [31:0] corners [8];
        corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0005_0000, 32'hFFFB_0000, 32'h0000_0001, 32'hFFFE_8000};
        foreach (corners[i]) begin
            send_command(CMD_NOISE_1D, corners[i], '0, '0);
            send_command(CMD_NOISE_2D, corners[i], corners[7 - i], '0);
        end
        send_command(CMD_RESERVED, '1, '1, '1);
        send_command(CMD_NOISE_2D, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    endtask

    // Period pairs with zero, one and the largest value, each followed by a 2D and a 1D command.
    task automatic test_period_settings();
        logic [15:0] periods [5];
        periods = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd256};
        foreach (periods[i]) begin
            drain_results();
            write_period(REG_PERIOD_X, periods[i]);
            write_period(REG_PERIOD_Y, periods[(i + 2) % 5]);
            send_command(CMD_NOISE_2D, 32'hFFF0_0000, 32'h0010_0000, '0);
            send_command(CMD_NOISE_1D, 32'hFFFF_8000, '0, '0);
        end
    endtask

    task automatic test_random_mix();
        logic [15:0] px;
        logic [15:0] py;
        int r;
        logic [1:0] cmd;
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            px = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(300, 1));
            py = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(300, 1));
            write_period(REG_PERIOD_X, px);
            write_period(REG_PERIOD_Y, py);
            stall_free = (phase % 3 == 1);
            for (int n = 0; n < 140; n++) begin
                r = $urandom_range(999);
                if (r < 10) cmd = CMD_RESEED;
                else if (r < 25) cmd = CMD_RESERVED;
                else if (r < 450) cmd = CMD_NOISE_1D;
                else cmd = CMD_NOISE_2D;
                send_command(cmd, random_coord(), random_coord(), {$urandom(), $urandom()});
                // One deliberate hold-off until the block is empty.
                if (phase == 4 && n == 70) begin
                    s_axis_tvalid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(negedge i_clk);
                end
            end
            stall_free = 1'b0;
        end
    endtask

    // Output side back-pressure, updated at the falling edge.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Result checker and idle watchdog.
    always @(posedge i_clk) begin
        noise_result_t want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: noise_value %0d result_kind %0d",
                           $signed(m_axis_tdata[18:0]), m_axis_tuser[0]);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[18:0] !== want.noise) begin
                        $error("noise_value: expected %0d, actual %0d",
                               want.noise, $signed(m_axis_tdata[18:0]));
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.kind, m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_NOISE_1D;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        reseed_count = 0;
        idle_cycles = 0;
        stall_free = 1'b0;
        gen_st = '0;
        per_x = PERIOD_RESET;
        per_y = PERIOD_RESET;
        for (int i = 0; i < 256; i++) begin
            perm_tab[i] = '0;
            used_map[i] = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reseed();
        test_coordinate_extremes();
        test_period_settings();
        test_random_mix();
        drain_results();

        $display("Sent %0d commands (%0d reseeds) and checked %0d results,",
                 sent_count, reseed_count, result_count);
        $display("over edge coordinates, zero/min/max periods and random back-pressure.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/gng_pkg.sv
src/gradient_noise_generator.sv
tb/gradient_noise_generator_test.sv
